// ===== rtl/rctok_pkg.sv =====
// Shared types and constants for the RESP command tokenizer.
// Used by rctok_parser and resp_command_tokenizer_top; no dependencies.
package rctok_pkg;

	localparam int unsigned LEN_WIDTH_DEF = 32;

	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_PLAIN,
		PH_NUM,
		PH_NUM_LF,
		PH_DOLLAR,
		PH_PAYLOAD,
		PH_SKIP,
		PH_DONE,
		PH_ERROR
	} phase_t;

	typedef enum logic [1:0] {
		ST_PRE,
		ST_SIGNED,
		ST_DIGITS,
		ST_TAIL
	} num_stage_t;

	typedef struct packed {
		logic [7:0] token_byte;
		logic       byte_valid;
		logic       token_begin;
		logic       token_end;
		logic       token_dropped;
		logic       resp_mode;
		logic       parse_error;
		logic       message_done;
	} result_t;

	function automatic logic is_space(input logic [7:0] b);
		return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
	endfunction

endpackage

// ===== rtl/rctok_parser.sv =====
// Parser state and per-byte decode for the RESP command tokenizer.
// Depends on rctok_pkg. State advances on each step; result is combinational.
module rctok_parser #(
	parameter int unsigned LEN_WIDTH = rctok_pkg::LEN_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          byte_in,
	input  logic                last_in,
	output rctok_pkg::result_t  result
);

	localparam int unsigned EW = LEN_WIDTH + 4;

	rctok_pkg::phase_t     phase_q, phase_mid, phase_d;
	rctok_pkg::num_stage_t stage_q, stage_mid, stage_d;
	logic [LEN_WIDTH-1:0]  elements_q, elements_mid, elements_d;
	logic [LEN_WIDTH-1:0]  accum_q, accum_mid, accum_d;
	logic [LEN_WIDTH-1:0]  payload_q, payload_mid, payload_d;
	logic                  neg_q, neg_mid, neg_d;
	logic                  seen_q, seen_mid, seen_d;
	logic                  inside_q, inside_mid, inside_d;
	logic                  is_count_q, is_count_mid, is_count_d;
	logic [1:0]            skip_q, skip_mid, skip_d;
	logic                  ev_valid, ev_begin, ev_end;

	logic [EW-1:0]         digit_sum;
	logic [LEN_WIDTH-1:0]  accum_next;
	logic                  is_digit;

	assign is_digit   = (byte_in >= rctok_pkg::CH_ZERO) && (byte_in <= rctok_pkg::CH_NINE);
	assign digit_sum  = ({4'b0, accum_q} << 3) + ({4'b0, accum_q} << 1)
		+ EW'(byte_in - rctok_pkg::CH_ZERO);
	assign accum_next = (|digit_sum[EW-1:LEN_WIDTH]) ? {LEN_WIDTH{1'b1}}
		: digit_sum[LEN_WIDTH-1:0];

	// per-byte decode, before message-end handling
	always_comb begin
		phase_mid    = phase_q;
		stage_mid    = stage_q;
		elements_mid = elements_q;
		accum_mid    = accum_q;
		payload_mid  = payload_q;
		neg_mid      = neg_q;
		seen_mid     = seen_q;
		inside_mid   = inside_q;
		is_count_mid = is_count_q;
		skip_mid     = skip_q;
		ev_valid     = 1'b0;
		ev_begin     = 1'b0;
		ev_end       = 1'b0;
		if (phase_q == rctok_pkg::PH_IDLE && byte_in == rctok_pkg::CH_STAR) begin
			phase_mid    = rctok_pkg::PH_NUM;
			stage_mid    = rctok_pkg::ST_PRE;
			is_count_mid = 1'b1;
			accum_mid    = '0;
			neg_mid      = 1'b0;
			seen_mid     = 1'b0;
		end else begin
			if (phase_q == rctok_pkg::PH_IDLE) begin
				phase_mid = rctok_pkg::PH_PLAIN;
			end
			unique case (phase_mid)
				rctok_pkg::PH_PLAIN: begin
					if (rctok_pkg::is_space(byte_in)) begin
						if (inside_q) begin
							ev_end     = 1'b1;
							inside_mid = 1'b0;
						end
					end else begin
						ev_valid   = 1'b1;
						ev_begin   = !inside_q;
						inside_mid = 1'b1;
					end
				end
				rctok_pkg::PH_NUM: begin
					priority if (byte_in == rctok_pkg::CH_CR) begin
						phase_mid = rctok_pkg::PH_NUM_LF;
					end else if (is_digit) begin
						if (stage_q != rctok_pkg::ST_TAIL) begin
							accum_mid = accum_next;
							seen_mid  = 1'b1;
							stage_mid = rctok_pkg::ST_DIGITS;
						end
					end else if (stage_q == rctok_pkg::ST_DIGITS
						|| stage_q == rctok_pkg::ST_TAIL) begin
						stage_mid = rctok_pkg::ST_TAIL;
					end else if (stage_q == rctok_pkg::ST_PRE
						&& (byte_in == rctok_pkg::CH_PLUS || byte_in == rctok_pkg::CH_MINUS)) begin
						neg_mid   = (byte_in == rctok_pkg::CH_MINUS);
						stage_mid = rctok_pkg::ST_SIGNED;
					end else if (stage_q == rctok_pkg::ST_PRE
						&& rctok_pkg::is_space(byte_in)) begin
						phase_mid = rctok_pkg::PH_NUM;
					end else begin
						phase_mid = rctok_pkg::PH_ERROR;
					end
				end
				rctok_pkg::PH_NUM_LF: begin
					priority if (byte_in != rctok_pkg::CH_LF || !seen_q) begin
						phase_mid = rctok_pkg::PH_ERROR;
					end else if (is_count_q) begin
						if (neg_q || accum_q == '0) begin
							phase_mid = rctok_pkg::PH_DONE;
						end else begin
							elements_mid = accum_q;
							phase_mid    = rctok_pkg::PH_DOLLAR;
						end
					end else if (neg_q && accum_q != '0) begin
						phase_mid = rctok_pkg::PH_ERROR;
					end else if (accum_q == '0) begin
						ev_begin     = 1'b1;
						ev_end       = 1'b1;
						elements_mid = elements_q - 1'b1;
						if (elements_q == LEN_WIDTH'(1)) begin
							phase_mid = rctok_pkg::PH_DONE;
						end else begin
							skip_mid  = 2'd2;
							phase_mid = rctok_pkg::PH_SKIP;
						end
					end else begin
						payload_mid = accum_q;
						inside_mid  = 1'b0;
						phase_mid   = rctok_pkg::PH_PAYLOAD;
					end
				end
				rctok_pkg::PH_DOLLAR: begin
					if (byte_in == rctok_pkg::CH_DOLLAR) begin
						phase_mid    = rctok_pkg::PH_NUM;
						stage_mid    = rctok_pkg::ST_PRE;
						is_count_mid = 1'b0;
						accum_mid    = '0;
						neg_mid      = 1'b0;
						seen_mid     = 1'b0;
					end else begin
						phase_mid = rctok_pkg::PH_ERROR;
					end
				end
				rctok_pkg::PH_PAYLOAD: begin
					ev_valid    = 1'b1;
					ev_begin    = !inside_q;
					inside_mid  = 1'b1;
					payload_mid = payload_q - 1'b1;
					if (payload_q == LEN_WIDTH'(1)) begin
						ev_end       = 1'b1;
						inside_mid   = 1'b0;
						elements_mid = elements_q - 1'b1;
						if (elements_q == LEN_WIDTH'(1)) begin
							phase_mid = rctok_pkg::PH_DONE;
						end else begin
							skip_mid  = 2'd2;
							phase_mid = rctok_pkg::PH_SKIP;
						end
					end
				end
				rctok_pkg::PH_SKIP: begin
					skip_mid = skip_q - 2'd1;
					if (skip_q == 2'd1) begin
						phase_mid = rctok_pkg::PH_DOLLAR;
					end
				end
				default: begin
					phase_mid = phase_q;
				end
			endcase
		end
	end

	// next state: message end returns everything to reset
	always_comb begin
		if (last_in) begin
			phase_d    = rctok_pkg::PH_IDLE;
			stage_d    = rctok_pkg::ST_PRE;
			elements_d = '0;
			accum_d    = '0;
			payload_d  = '0;
			neg_d      = 1'b0;
			seen_d     = 1'b0;
			inside_d   = 1'b0;
			is_count_d = 1'b0;
			skip_d     = 2'd0;
		end else begin
			phase_d    = phase_mid;
			stage_d    = stage_mid;
			elements_d = elements_mid;
			accum_d    = accum_mid;
			payload_d  = payload_mid;
			neg_d      = neg_mid;
			seen_d     = seen_mid;
			inside_d   = inside_mid;
			is_count_d = is_count_mid;
			skip_d     = skip_mid;
		end
	end

	// result for this byte
	always_comb begin
		result.token_byte    = ev_valid ? byte_in : 8'h00;
		result.byte_valid    = ev_valid;
		result.token_begin   = ev_begin;
		result.token_end     = ev_end
			|| (last_in && phase_mid == rctok_pkg::PH_PLAIN && inside_mid);
		result.token_dropped = last_in && phase_mid == rctok_pkg::PH_PAYLOAD && inside_mid;
		result.resp_mode     = (phase_mid != rctok_pkg::PH_PLAIN);
		result.parse_error   = (phase_mid == rctok_pkg::PH_ERROR)
			|| (last_in && phase_mid != rctok_pkg::PH_PLAIN
				&& phase_mid != rctok_pkg::PH_DONE);
		result.message_done  = last_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= rctok_pkg::PH_IDLE;
			stage_q    <= rctok_pkg::ST_PRE;
			elements_q <= '0;
			accum_q    <= '0;
			payload_q  <= '0;
			neg_q      <= 1'b0;
			seen_q     <= 1'b0;
			inside_q   <= 1'b0;
			is_count_q <= 1'b0;
			skip_q     <= 2'd0;
		end else if (step) begin
			phase_q    <= phase_d;
			stage_q    <= stage_d;
			elements_q <= elements_d;
			accum_q    <= accum_d;
			payload_q  <= payload_d;
			neg_q      <= neg_d;
			seen_q     <= seen_d;
			inside_q   <= inside_d;
			is_count_q <= is_count_d;
			skip_q     <= skip_d;
		end
	end

endmodule

// ===== rtl/resp_command_tokenizer_top.sv =====
// Top level of the RESP command tokenizer: input register, parser, result register.
// Depends on rctok_pkg and rctok_parser.
//
// Takes one message byte per transaction and returns exactly one result
// transaction per byte, in order. Messages starting with '*' are parsed as a
// RESP array of bulk strings; anything else is split at whitespace. The block
// sustains one byte per clock unless token_stall holds it back; a byte passes
// through the input register and then the result register before its result
// appears. The rate is set by the parser's state update, which takes one byte
// on each step. msg_stall rises only when both registers are full and token_stall
// is high. Length and count fields are LEN_WIDTH bits and saturate.
module resp_command_tokenizer_top #(
	parameter int unsigned LEN_WIDTH = rctok_pkg::LEN_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       msg_valid,
	output logic       msg_stall,
	input  logic [7:0] msg_byte,
	input  logic       msg_last,
	output logic       token_valid,
	input  logic       token_stall,
	output logic [7:0] token_byte,
	output logic       byte_valid,
	output logic       token_begin,
	output logic       token_end,
	output logic       token_dropped,
	output logic       resp_mode,
	output logic       parse_error,
	output logic       message_done
);

	logic               valid_s1;
	logic [7:0]         byte_s1;
	logic               last_s1;
	logic               out_ready;
	logic               step;
	rctok_pkg::result_t result;
	rctok_pkg::result_t result_q;
	logic               valid_q;

	assign out_ready = !valid_q || !token_stall;
	assign step      = valid_s1 && out_ready;
	assign msg_stall = valid_s1 && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (msg_valid && !msg_stall) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (msg_valid && !msg_stall) begin
			byte_s1 <= msg_byte;
			last_s1 <= msg_last;
		end
	end

	rctok_parser #(
		.LEN_WIDTH(LEN_WIDTH)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.byte_in (byte_s1),
		.last_in (last_s1),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_ready) begin
			valid_q <= step;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_q <= result;
		end
	end

	assign token_valid   = valid_q;
	assign token_byte    = result_q.token_byte;
	assign byte_valid    = result_q.byte_valid;
	assign token_begin   = result_q.token_begin;
	assign token_end     = result_q.token_end;
	assign token_dropped = result_q.token_dropped;
	assign resp_mode     = result_q.resp_mode;
	assign parse_error   = result_q.parse_error;
	assign message_done  = result_q.message_done;

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		msg_stall |-> (valid_s1 && valid_q && token_stall))
		else $error("input stalled while a register was free");

	a_idle_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(token_valid && !byte_valid) |-> (token_byte == 8'h00))
		else $error("token_byte nonzero without a payload byte");

	a_drop_ends_message: assert property (@(posedge clk) disable iff (!arst_n)
		(token_valid && token_dropped) |-> (message_done && parse_error && resp_mode))
		else $error("dropped token outside an erroring RESP message end");

	a_plain_no_error: assert property (@(posedge clk) disable iff (!arst_n)
		(token_valid && !resp_mode) |-> (!parse_error && !token_dropped))
		else $error("error flagged in whitespace mode");

endmodule
